/* src/eq3_pkg.sv */
`timescale 1ns / 1ps

package eq3_pkg;

    localparam int NUM_STAGES     = 3;
    localparam int COEF_FRAC_BITS = 18;
    localparam int NUM_COEFS      = 5;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 24;
    localparam int TAP_W       = 32;
    localparam int PROD_W      = COEF_W + TAP_W;
    localparam int ACC_W       = 64;
    localparam int STAGE_SEL_W = 2;
    localparam int COEF_SEL_W  = 3;
    localparam int STAGE_W     = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

    // Item kinds.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    // Coefficient slots; the MAC step counter walks them in this order.
    localparam logic [COEF_SEL_W-1:0] SLOT_B0 = 3'd0;
    localparam logic [COEF_SEL_W-1:0] SLOT_B1 = 3'd1;
    localparam logic [COEF_SEL_W-1:0] SLOT_B2 = 3'd2;
    localparam logic [COEF_SEL_W-1:0] SLOT_A1 = 3'd3;
    localparam logic [COEF_SEL_W-1:0] SLOT_A2 = 3'd4;

    typedef struct packed {
        logic                  load_sample;
        logic                  write_coef;
        logic                  mul_en;
        logic                  acc_en;
        logic                  finish;
        logic                  out_load;
        logic [STAGE_W-1:0]    stage;
        logic [COEF_SEL_W-1:0] step;
    } eq3_cmd_t;

endpackage

/* src/eq3_datapath.sv */
`timescale 1ns / 1ps

module eq3_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  eq3_pkg::eq3_cmd_t                      cmd,
    input  logic signed [eq3_pkg::SAMPLE_W-1:0]    left_sample,
    input  logic signed [eq3_pkg::SAMPLE_W-1:0]    right_sample,
    input  logic        [eq3_pkg::STAGE_SEL_W-1:0] stage_select,
    input  logic        [eq3_pkg::COEF_SEL_W-1:0]  coef_select,
    input  logic signed [eq3_pkg::COEF_W-1:0]      coef_value,
    output logic signed [eq3_pkg::SAMPLE_W-1:0]    sample_out
);
    import eq3_pkg::*;

    typedef struct packed {
        logic signed [TAP_W-1:0] x1;
        logic signed [TAP_W-1:0] x2;
        logic signed [TAP_W-1:0] y1;
        logic signed [TAP_W-1:0] y2;
    } eq3_taps_t;

    localparam logic signed [ACC_W-1:0] ROUND_INIT = 64'sd1 <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] Y_MAX      = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0] Y_MIN      = -Y_MAX - 64'sd1;
    localparam logic signed [TAP_W-1:0] OUT_MAX    = 32'sd32767;
    localparam logic signed [TAP_W-1:0] OUT_MIN    = -32'sd32768;

    logic signed [COEF_W-1:0] coef_reg [NUM_STAGES][NUM_COEFS];
    eq3_taps_t                taps_reg [NUM_STAGES];

    logic signed [TAP_W-1:0]    x_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       prod_sub_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;

    logic [STAGE_W+STAGE_SEL_W-1:0] stage_ext;
    logic [STAGE_W-1:0]             wr_stage;
    logic                           wr_ok;
    logic signed [SAMPLE_W:0]       pair_sum;
    logic signed [SAMPLE_W:0]       pair_half;
    eq3_taps_t                      row;
    logic signed [COEF_W-1:0]       coef_sel;
    logic signed [TAP_W-1:0]        op_sel;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [ACC_W-1:0]        acc_next;
    logic signed [ACC_W-1:0]        acc_shift;
    logic signed [TAP_W-1:0]        y_next;

    always_comb
    begin
        stage_ext = (STAGE_W + STAGE_SEL_W)'(stage_select);
        wr_stage  = stage_ext[STAGE_W-1:0];
        wr_ok     = (int'(stage_select) < NUM_STAGES) && (int'(coef_select) < NUM_COEFS);
    end

    // Halving that truncates toward zero: add one to a negative sum first.
    always_comb
    begin
        pair_sum  = (SAMPLE_W + 1)'(left_sample) + (SAMPLE_W + 1)'(right_sample);
        pair_half = (pair_sum + $signed({{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]})) >>> 1;
    end

    always_comb
    begin
        row      = taps_reg[cmd.stage];
        coef_sel = coef_reg[cmd.stage][cmd.step];
        case (cmd.step)
            SLOT_B0: op_sel = x_reg;
            SLOT_B1: op_sel = row.x1;
            SLOT_B2: op_sel = row.x2;
            SLOT_A1: op_sel = row.y1;
            SLOT_A2: op_sel = row.y2;
            default: op_sel = '0;
        endcase
        prod_next = coef_sel * op_sel;
    end

    always_comb
    begin
        if (prod_sub_reg)
        begin
            acc_next = acc_reg - ACC_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    // The accumulator starts at half an LSB, so the shift rounds half up.
    always_comb
    begin
        acc_shift = acc_reg >>> COEF_FRAC_BITS;
        if (acc_shift > Y_MAX)
        begin
            y_next = TAP_W'(Y_MAX);
        end
        else if (acc_shift < Y_MIN)
        begin
            y_next = TAP_W'(Y_MIN);
        end
        else
        begin
            y_next = TAP_W'(acc_shift);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                taps_reg[s] <= '0;
                for (int k = 0; k < NUM_COEFS; k++)
                begin
                    coef_reg[s][k] <= '0;
                end
            end
        end
        else
        begin
            if (cmd.write_coef && wr_ok)
            begin
                coef_reg[wr_stage][coef_select] <= coef_value;
            end
            if (cmd.finish)
            begin
                taps_reg[cmd.stage].x2 <= row.x1;
                taps_reg[cmd.stage].x1 <= x_reg;
                taps_reg[cmd.stage].y2 <= row.y1;
                taps_reg[cmd.stage].y1 <= y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            x_reg <= TAP_W'(pair_half);
        end
        else if (cmd.finish)
        begin
            x_reg <= y_next;
        end

        if (cmd.load_sample || cmd.finish)
        begin
            acc_reg <= ROUND_INIT;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_next;
        end

        if (cmd.mul_en)
        begin
            prod_reg     <= prod_next;
            prod_sub_reg <= (cmd.step == SLOT_A1) || (cmd.step == SLOT_A2);
        end

        if (cmd.out_load)
        begin
            if (x_reg > OUT_MAX)
            begin
                sample_out_reg <= SAMPLE_W'(OUT_MAX);
            end
            else if (x_reg < OUT_MIN)
            begin
                sample_out_reg <= SAMPLE_W'(OUT_MIN);
            end
            else
            begin
                sample_out_reg <= SAMPLE_W'(x_reg);
            end
        end
    end

    assign sample_out = sample_out_reg;

endmodule

/* src/eq3_ctrl.sv */
`timescale 1ns / 1ps

module eq3_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              kind,
    output logic              out_valid,
    input  logic              out_stall,
    output eq3_pkg::eq3_cmd_t cmd
);
    import eq3_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_LAST = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(NUM_STAGES - 1);

    logic [2:0]            state_reg, state_next;
    logic [STAGE_W-1:0]    stage_reg, stage_next;
    logic [COEF_SEL_W-1:0] step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  in_accept;
    logic                  out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        stage_next     = stage_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;

        cmd             = '0;
        cmd.stage       = stage_reg;
        cmd.step        = step_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_sample = in_accept && (kind == KIND_SAMPLE);
                cmd.write_coef  = in_accept && (kind == KIND_COEF);
                if (cmd.load_sample)
                begin
                    state_next = ST_MAC;
                    stage_next = '0;
                    step_next  = SLOT_B0;
                end
            end
            ST_MAC:
            begin
                // Each cycle issues one product and, past the first slot, adds the one before it.
                cmd.mul_en = 1'b1;
                cmd.acc_en = (step_reg != SLOT_B0);
                if (step_reg == SLOT_A2)
                begin
                    state_next = ST_LAST;
                    step_next  = SLOT_B0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_LAST:
            begin
                cmd.acc_en = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                if (stage_reg == LAST_STAGE)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    stage_next = stage_reg + 1'b1;
                    state_next = ST_MAC;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stage_reg     <= '0;
            step_reg      <= SLOT_B0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("result register loaded while a result is held");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= SLOT_A2)
        else $error("MAC step counter out of range");

    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg <= LAST_STAGE)
        else $error("stage counter out of range");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_sample |=> !cmd.out_load && (state_reg == ST_MAC))
        else $error("sample did not enter the MAC sequence");
`endif

endmodule

/* src/three_band_biquad_eq_cascade.sv */
// Channel   Handshake                 Payload
// input     in_valid / in_stall       kind, left_sample, right_sample,
//                                     stage_select, coef_select, coef_value
// output    out_valid / out_stall     sample_out
//
// A sample pair is taken in the idle state, then runs through each biquad stage on
// the single shared multiplier (five products, a last add, then the round and tap
// update), and then loads the result register. A coefficient write is taken in idle.
// Reset clears the coefficients, the delay taps and the control state at once.
// A result held by out_stall does not block the next transfer in; the block
// waits only if a new result is ready before the held one is taken.
`timescale 1ns / 1ps

module three_band_biquad_eq_cascade
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   kind,
    input  logic signed [eq3_pkg::SAMPLE_W-1:0]    left_sample,
    input  logic signed [eq3_pkg::SAMPLE_W-1:0]    right_sample,
    input  logic        [eq3_pkg::STAGE_SEL_W-1:0] stage_select,
    input  logic        [eq3_pkg::COEF_SEL_W-1:0]  coef_select,
    input  logic signed [eq3_pkg::COEF_W-1:0]      coef_value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [eq3_pkg::SAMPLE_W-1:0]    sample_out
);
    import eq3_pkg::*;

    eq3_cmd_t cmd;

    eq3_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    eq3_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .stage_select (stage_select),
        .coef_select  (coef_select),
        .coef_value   (coef_value),
        .sample_out   (sample_out)
    );

endmodule
